>>> hw/rtl/dfam_pkg.sv
`timescale 1ns / 1ps
package dfam_pkg;
    localparam int MAX_STATES_DEF  = 16;
    localparam int MAX_SYMBOLS_DEF = 4;

    typedef enum logic [1:0] {
        OP_WRITE_TRANS  = 2'd0,
        OP_WRITE_ACCEPT = 2'd1,
        OP_RUN          = 2'd2,
        OP_NONE         = 2'd3
    } op_t;

    localparam logic [1:0] CFG_NUM_STATES  = 2'd0;
    localparam logic [1:0] CFG_NUM_SYMBOLS = 2'd1;
    localparam logic [1:0] CFG_START_STATE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REACH_RD,
        ST_REACH_UPD,
        ST_INIT_MARK,
        ST_FILL_RD_S,
        ST_FILL_RD_P,
        ST_FILL_CHK,
        ST_CLASS_SCAN,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } state_t;
endpackage

>>> hw/rtl/dfam_ram.sv
`timescale 1ns / 1ps
module dfam_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hw/rtl/dfa_minimizer_core.sv
`timescale 1ns / 1ps
// DFA minimizer. Load items (transition or accept flag writes) are taken one per cycle while
// the block is idle and produce no output. A run item occupies the block until its last result
// is taken: it walks the transition RAM through its single registered read port. The
// reachability pass sweeps the states, repeated until nothing changes; each table-filling
// sweep tests up to N*(N-1)/2 pairs, repeated until nothing changes; class numbering
// follows; output gives one (class, symbol) result at a time and holds it while the master
// side stalls. No clearing pass is needed after reset.
module dfa_minimizer_core #(
    parameter int MAX_STATES  = dfam_pkg::MAX_STATES_DEF,
    parameter int MAX_SYMBOLS = dfam_pkg::MAX_SYMBOLS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[1:0], state_index[5:2], symbol_index[7:6], target_state[11:8], accepting[12]
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // class_state[3:0], symbol[5:4], class_target[9:6], class_accepting[10], class_is_start[11]
    output logic [15:0] m_tdata,
    output logic        m_tlast
);
    localparam int SW = $clog2(MAX_STATES);
    localparam int KB = $clog2(MAX_SYMBOLS);
    localparam int AW = SW + KB;

    localparam logic [1:0] CFG_IDX0 = dfam_pkg::CFG_NUM_STATES;
    localparam logic [1:0] CFG_IDX1 = dfam_pkg::CFG_NUM_SYMBOLS;
    localparam logic [1:0] CFG_IDX2 = dfam_pkg::CFG_START_STATE;

    logic [4:0] num_states_reg;
    logic [2:0] num_symbols_reg;
    logic [3:0] start_state_reg;

    logic [MAX_STATES-1:0] accept_reg;
    logic [MAX_STATES-1:0] reach_reg, reach_next;
    logic [MAX_STATES-1:0] dist_reg [MAX_STATES];
    logic [3:0]            cls_reg  [MAX_STATES];
    logic [3:0]            rep_reg  [MAX_STATES];

    dfam_pkg::state_t st_reg, st_next;
    logic [SW-1:0] s_reg, s_next, p_reg, p_next;
    logic [2:0]    a_reg, a_next;
    logic          chg_reg, chg_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic          found_reg, found_next;
    logic [SW-1:0] ts_reg, ts_next;
    logic          rd_ph_reg, rd_ph_next;

    // decode input transaction
    logic [1:0] in_op;
    logic [3:0] in_si, in_tgt;
    logic [1:0] in_sym;
    logic       in_acc;
    assign in_op  = s_tdata[1:0];
    assign in_si  = s_tdata[5:2];
    assign in_sym = s_tdata[7:6];
    assign in_tgt = s_tdata[11:8];
    assign in_acc = s_tdata[12];

    // clamp configuration
    logic [4:0] n_use;
    logic [2:0] k_use;
    logic [SW-1:0] start_use, last_st;
    always_comb
    begin
        n_use = num_states_reg;
        if (n_use == 5'd0) n_use = 5'd1;
        if (n_use > 5'(MAX_STATES)) n_use = 5'(MAX_STATES);
        k_use = num_symbols_reg;
        if (k_use == 3'd0) k_use = 3'd1;
        if (k_use > 3'(MAX_SYMBOLS)) k_use = 3'(MAX_SYMBOLS);
        last_st = SW'(n_use - 5'd1);
        start_use = (5'(start_state_reg) >= n_use) ? last_st : SW'(start_state_reg);
    end

    logic acc_in;
    assign s_tready = (st_reg == dfam_pkg::ST_IDLE);
    assign acc_in = s_tvalid && s_tready;

    // transition RAM
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [3:0]    ram_rdata;
    logic [SW-1:0] rd_state;
    assign ram_we = acc_in && (in_op == dfam_pkg::OP_WRITE_TRANS)
                    && (5'(in_si) < 5'(MAX_STATES)) && (3'(in_sym) < 3'(MAX_SYMBOLS));
    generate
        if (KB > 0)
        begin : g_addr
            assign ram_waddr = {in_si[SW-1:0], in_sym[KB-1:0]};
            assign ram_raddr = {rd_state, a_reg[KB-1:0]};
        end
        else
        begin : g_addr1
            assign ram_waddr = in_si[SW-1:0];
            assign ram_raddr = rd_state;
        end
    endgenerate

    dfam_ram #(.WIDTH(4), .DEPTH(1 << AW)) u_ram (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(in_tgt),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    // clamp read target
    logic [SW-1:0] rd_t;
    assign rd_t = (5'(ram_rdata) >= n_use) ? last_st : SW'(ram_rdata);

    // pair lookup helper
    function automatic logic marked(input logic [SW-1:0] x, input logic [SW-1:0] y,
                                    input logic [MAX_STATES-1:0] d [MAX_STATES]);
        logic [SW-1:0] lo, hi;
        lo = (x < y) ? x : y;
        hi = (x < y) ? y : x;
        return (lo != hi) && d[lo][hi];
    endfunction

    logic out_v_reg;
    logic out_take;
    assign out_take = out_v_reg && m_tready;

    logic last_sym, last_cls;
    assign last_sym = (a_reg == k_use - 3'd1);
    assign last_cls = (5'(s_reg) + 5'd1 == cnt_reg);

    // sequencer
    always_comb
    begin
        st_next = st_reg; s_next = s_reg; p_next = p_reg; a_next = a_reg;
        chg_next = chg_reg; cnt_next = cnt_reg; found_next = found_reg;
        ts_next = ts_reg; rd_ph_next = rd_ph_reg; reach_next = reach_reg;
        rd_state = s_reg;
        case (st_reg)
            dfam_pkg::ST_IDLE:
            begin
                if (acc_in && in_op == dfam_pkg::OP_RUN)
                begin
                    reach_next = '0;
                    reach_next[start_use] = 1'b1;
                    s_next = '0; a_next = '0; chg_next = 1'b0;
                    st_next = dfam_pkg::ST_REACH_RD;
                end
            end
            dfam_pkg::ST_REACH_RD:
            begin
                if (!reach_reg[s_reg])
                begin
                    if (s_reg == last_st)
                    begin
                        s_next = '0;
                        if (chg_reg) chg_next = 1'b0;
                        else st_next = dfam_pkg::ST_INIT_MARK;
                    end
                    else s_next = s_reg + 1'b1;
                end
                else st_next = dfam_pkg::ST_REACH_UPD;
            end
            dfam_pkg::ST_REACH_UPD:
            begin
                if (!reach_reg[rd_t])
                begin
                    reach_next[rd_t] = 1'b1;
                    chg_next = 1'b1;
                end
                st_next = dfam_pkg::ST_REACH_RD;
                if (last_sym)
                begin
                    a_next = '0;
                    if (s_reg == last_st)
                    begin
                        s_next = '0;
                        if (chg_reg || !reach_reg[rd_t]) chg_next = 1'b0;
                        else st_next = dfam_pkg::ST_INIT_MARK;
                    end
                    else s_next = s_reg + 1'b1;
                end
                else a_next = a_reg + 3'd1;
            end
            dfam_pkg::ST_INIT_MARK:
            begin
                s_next = '0; p_next = SW'(1); a_next = '0; chg_next = 1'b0;
                rd_ph_next = 1'b0;
                st_next = (last_st == '0) ? dfam_pkg::ST_CLASS_SCAN : dfam_pkg::ST_FILL_RD_S;
                if (last_st == '0) begin s_next = '0; p_next = '0; cnt_next = '0; end
            end
            dfam_pkg::ST_FILL_RD_S:
            begin
                // skip pairs that need no test
                if (!reach_reg[s_reg] || !reach_reg[p_reg] || dist_reg[s_reg][p_reg])
                begin
                    if (p_reg == last_st)
                    begin
                        if (5'(s_reg) + 5'd2 >= n_use)
                        begin
                            s_next = '0; p_next = SW'(1);
                            if (chg_reg) chg_next = 1'b0;
                            else
                            begin
                                p_next = '0; cnt_next = '0; found_next = 1'b0;
                                st_next = dfam_pkg::ST_CLASS_SCAN;
                            end
                        end
                        else
                        begin
                            s_next = s_reg + 1'b1; p_next = s_reg + SW'(2);
                        end
                    end
                    else p_next = p_reg + 1'b1;
                end
                else
                begin
                    rd_state = s_reg;
                    st_next = dfam_pkg::ST_FILL_RD_P;
                end
            end
            dfam_pkg::ST_FILL_RD_P:
            begin
                rd_state = p_reg;
                ts_next = rd_t;
                st_next = dfam_pkg::ST_FILL_CHK;
            end
            dfam_pkg::ST_FILL_CHK:
            begin
                rd_state = p_reg;
                if (!rd_ph_reg)
                begin
                    rd_ph_next = 1'b1;
                end
                else
                begin
                    rd_ph_next = 1'b0;
                    a_next = '0;
                    st_next = dfam_pkg::ST_FILL_RD_S;
                    if (marked(ts_reg, rd_t, dist_reg))
                        chg_next = 1'b1;
                    else if (!last_sym)
                        a_next = a_reg + 3'd1;
                    else
                    begin
                        // pair survives every symbol: advance to the next pair
                        if (p_reg == last_st)
                        begin
                            if (5'(s_reg) + 5'd2 >= n_use)
                            begin
                                s_next = '0; p_next = SW'(1);
                                if (chg_reg) chg_next = 1'b0;
                                else
                                begin
                                    p_next = '0; cnt_next = '0; found_next = 1'b0;
                                    st_next = dfam_pkg::ST_CLASS_SCAN;
                                end
                            end
                            else
                            begin
                                s_next = s_reg + 1'b1; p_next = s_reg + SW'(2);
                            end
                        end
                        else p_next = p_reg + 1'b1;
                    end
                end
                if (!rd_ph_reg) st_next = dfam_pkg::ST_FILL_CHK;
            end
            dfam_pkg::ST_CLASS_SCAN:
            begin
                if (p_reg == s_reg || (reach_reg[p_reg] && !dist_reg[p_reg][s_reg]
                                       && p_reg != s_reg))
                begin
                    if (reach_reg[s_reg] && p_reg == s_reg && !found_reg)
                        cnt_next = cnt_reg + 5'd1;
                    p_next = '0; found_next = 1'b0;
                    if (s_reg == last_st)
                    begin
                        s_next = '0; a_next = '0;
                        st_next = dfam_pkg::ST_EMIT_RD;
                    end
                    else s_next = s_reg + 1'b1;
                end
                else p_next = p_reg + 1'b1;
            end
            dfam_pkg::ST_EMIT_RD:
            begin
                rd_state = SW'(rep_reg[s_reg]);
                if (!rd_ph_reg) rd_ph_next = 1'b1;
                else
                begin
                    rd_ph_next = 1'b0;
                    st_next = dfam_pkg::ST_EMIT_OUT;
                end
            end
            dfam_pkg::ST_EMIT_OUT:
            begin
                rd_state = SW'(rep_reg[s_reg]);
                if (out_take)
                begin
                    if (last_sym)
                    begin
                        a_next = '0;
                        if (last_cls) st_next = dfam_pkg::ST_IDLE;
                        else
                        begin
                            s_next = s_reg + 1'b1;
                            st_next = dfam_pkg::ST_EMIT_RD;
                        end
                    end
                    else
                    begin
                        a_next = a_reg + 3'd1;
                        st_next = dfam_pkg::ST_EMIT_RD;
                    end
                end
            end
            default: st_next = dfam_pkg::ST_IDLE;
        endcase
    end

    // FILL_CHK holds rd_state at p while the read lands
    // (read of p issued in FILL_RD_P; s read issued in FILL_RD_S lands there)

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= dfam_pkg::ST_IDLE;
            s_reg <= '0; p_reg <= '0; a_reg <= '0; chg_reg <= 1'b0;
            cnt_reg <= '0; found_reg <= 1'b0; rd_ph_reg <= 1'b0; ts_reg <= '0;
            num_states_reg <= 5'd16; num_symbols_reg <= 3'd4; start_state_reg <= 4'd0;
            accept_reg <= '0; reach_reg <= '0; out_v_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next; s_reg <= s_next; p_reg <= p_next; a_reg <= a_next;
            chg_reg <= chg_next; cnt_reg <= cnt_next; found_reg <= found_next;
            rd_ph_reg <= rd_ph_next; reach_reg <= reach_next; ts_reg <= ts_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_IDX0: num_states_reg <= cfg_data;
                    CFG_IDX1: num_symbols_reg <= cfg_data[2:0];
                    CFG_IDX2: start_state_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (acc_in && in_op == dfam_pkg::OP_WRITE_ACCEPT && 5'(in_si) < 5'(MAX_STATES))
                accept_reg[in_si[SW-1:0]] <= in_acc;
            if (st_reg == dfam_pkg::ST_EMIT_RD && rd_ph_reg) out_v_reg <= 1'b1;
            else if (out_take) out_v_reg <= 1'b0;
        end
    end

    // pair table, class table and output payload
    logic [15:0] out_data_reg;
    logic        out_last_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_STATES; i++)
            begin
                dist_reg[i] <= '0;
                cls_reg[i] <= '0;
            end
        end
        else
        begin
            if (st_reg == dfam_pkg::ST_INIT_MARK)
            begin
                for (int i = 0; i < MAX_STATES; i++)
                begin
                    cls_reg[i] <= '0;
                    for (int j = 0; j < MAX_STATES; j++)
                        dist_reg[i][j] <= (j > i) && (j < int'(n_use)) && reach_reg[i]
                                          && reach_reg[j] && (accept_reg[i] != accept_reg[j]);
                end
            end
            if (st_reg == dfam_pkg::ST_FILL_CHK && rd_ph_reg && marked(ts_reg, rd_t, dist_reg))
                dist_reg[s_reg][p_reg] <= 1'b1;
            if (st_reg == dfam_pkg::ST_CLASS_SCAN && reach_reg[s_reg])
            begin
                if (p_reg != s_reg && reach_reg[p_reg] && !dist_reg[p_reg][s_reg])
                    cls_reg[s_reg] <= cls_reg[p_reg];
                else if (p_reg == s_reg)
                    cls_reg[s_reg] <= cnt_reg[3:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == dfam_pkg::ST_CLASS_SCAN && reach_reg[s_reg] && p_reg == s_reg)
            rep_reg[cnt_reg[SW-1:0]] <= 4'(s_reg);
        if (st_reg == dfam_pkg::ST_EMIT_RD && rd_ph_reg)
        begin
            out_data_reg <= {4'd0, (cls_reg[start_use] == 4'(s_reg) ? 1'b1 : 1'b0),
                             accept_reg[rep_reg[s_reg][SW-1:0]], cls_reg[rd_t],
                             a_reg[1:0], 4'(s_reg)};
            out_last_reg <= last_cls && last_sym;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
endmodule

>>> hw/rtl/dfam_checker.sv
`timescale 1ns / 1ps
module dfam_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);
    // no input is taken while a result is on offer
    assert property (@(posedge clk) disable iff (!rst_n) m_tvalid |-> !s_tready)
        else $error("input accepted during output");
    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");
    // run item makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tdata[1:0] == dfam_pkg::OP_RUN |=> !s_tready)
        else $error("run did not start");
    // block is ready again after the last result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
        else $error("not idle after last");
endmodule

bind dfa_minimizer_core dfam_checker u_dfam_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast)
);

>>> sim/dfa_minimizer_core_tb.sv
`timescale 1ns / 1ps
module dfa_minimizer_core_tb;

    typedef struct {
        logic [3:0] class_state;
        logic [1:0] symbol;
        logic [3:0] class_target;
        logic       class_accepting;
        logic       class_is_start;
        logic       last;
    } min_edge_t;

    // Minimized-table predictor and store of pending edges
    class min_table_board;
        logic [3:0]  trans_mem[dfam_pkg::MAX_STATES_DEF*dfam_pkg::MAX_SYMBOLS_DEF];
        logic [15:0] accept_mask;
        logic [15:0] reach_mask;
        logic [15:0] diff_rows[dfam_pkg::MAX_STATES_DEF];
        logic [4:0]  reg_states;
        logic [2:0]  reg_symbols;
        logic [3:0]  reg_start;
        min_edge_t   pending_edges[$];
        int          mismatches;

        function new();
            foreach (trans_mem[i]) trans_mem[i] = '0;
            accept_mask = '0;
            reg_states  = 5'd16;
            reg_symbols = 3'd4;
            reg_start   = 4'd0;
            mismatches  = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [4:0] val);
            if (idx == dfam_pkg::CFG_NUM_STATES) reg_states = val;
            else if (idx == dfam_pkg::CFG_NUM_SYMBOLS) reg_symbols = val[2:0];
            else if (idx == dfam_pkg::CFG_START_STATE) reg_start = val[3:0];
        endfunction

        function int succ(int s, int a, int n);
            int v;
            v = trans_mem[s*dfam_pkg::MAX_SYMBOLS_DEF + a];
            if (v >= n) v = n - 1;
            return v;
        endfunction

        function bit differs(int a, int b);
            int lo;
            int hi;
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            if (lo == hi) return 0;
            return diff_rows[lo][hi];
        endfunction

        function void predict_run();
            int n;
            int k;
            int start;
            int count;
            int cls[dfam_pkg::MAX_STATES_DEF];
            int rep[dfam_pkg::MAX_STATES_DEF];
            bit changed;
            bit found;
            min_edge_t e;
            n = (reg_states < 1) ? 1 : ((reg_states > 16) ? 16 : reg_states);
            k = (reg_symbols < 1) ? 1 : ((reg_symbols > 4) ? 4 : reg_symbols);
            start = (reg_start >= n) ? n - 1 : reg_start;
            // reachability from start
            reach_mask = '0;
            reach_mask[start] = 1'b1;
            do begin
                changed = 0;
                for (int s = 0; s < n; s++)
                    if (reach_mask[s])
                        for (int a = 0; a < k; a++)
                            if (!reach_mask[succ(s, a, n)]) begin
                                reach_mask[succ(s, a, n)] = 1'b1;
                                changed = 1;
                            end
            end while (changed);
            // mark pairs split by acceptance
            foreach (diff_rows[i]) diff_rows[i] = '0;
            for (int s = 0; s < n; s++)
                for (int p = s + 1; p < n; p++)
                    if (reach_mask[s] && reach_mask[p] && accept_mask[s] != accept_mask[p])
                        diff_rows[s][p] = 1'b1;
            // table filling until stable
            do begin
                changed = 0;
                for (int s = 0; s < n; s++) begin
                    if (!reach_mask[s]) continue;
                    for (int p = s + 1; p < n; p++) begin
                        if (!reach_mask[p] || differs(s, p)) continue;
                        for (int a = 0; a < k; a++)
                            if (differs(succ(s, a, n), succ(p, a, n))) begin
                                diff_rows[s][p] = 1'b1;
                                changed = 1;
                                break;
                            end
                    end
                end
            end while (changed);
            // number classes by smallest member
            count = 0;
            foreach (cls[i]) cls[i] = 0;
            for (int s = 0; s < n; s++) begin
                if (!reach_mask[s]) continue;
                found = 0;
                for (int p = 0; p < s; p++)
                    if (reach_mask[p] && !differs(p, s)) begin
                        cls[s] = cls[p];
                        found = 1;
                        break;
                    end
                if (!found) begin
                    cls[s] = count;
                    rep[count] = s;
                    count++;
                end
            end
            for (int c = 0; c < count; c++)
                for (int a = 0; a < k; a++) begin
                    e.class_state     = c[3:0];
                    e.symbol          = a[1:0];
                    e.class_target    = cls[succ(rep[c], a, n)][3:0];
                    e.class_accepting = accept_mask[rep[c]];
                    e.class_is_start  = (cls[start] == c);
                    e.last            = (c + 1 == count) && (a + 1 == k);
                    pending_edges.insert(pending_edges.size(), e);
                end
        endfunction

        function void note_input(logic [15:0] d);
            dfam_pkg::op_t op;
            op = dfam_pkg::op_t'(d[1:0]);
            case (op)
                dfam_pkg::OP_WRITE_TRANS:
                    trans_mem[d[5:2]*dfam_pkg::MAX_SYMBOLS_DEF + d[7:6]] = d[11:8];
                dfam_pkg::OP_WRITE_ACCEPT: accept_mask[d[5:2]] = d[12];
                dfam_pkg::OP_RUN:          predict_run();
                default: ;
            endcase
        endfunction

        function void check_result(logic [15:0] d, logic l);
            min_edge_t e;
            if (pending_edges.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result tdata=%h tlast=%b", d, l);
                return;
            end
            e = pending_edges.pop_front();
            if (d[3:0] !== e.class_state || d[5:4] !== e.symbol ||
                d[9:6] !== e.class_target || d[10] !== e.class_accepting ||
                d[11] !== e.class_is_start || l !== e.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch exp cls=%0d sym=%0d tgt=%0d acc=%b st=%b last=%b,",
                              " got cls=%0d sym=%0d tgt=%0d acc=%b st=%b last=%b"},
                             e.class_state, e.symbol, e.class_target, e.class_accepting,
                             e.class_is_start, e.last, d[3:0], d[5:4], d[9:6], d[10],
                             d[11], l);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [4:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;

    min_table_board board;
    bit  zero_gaps;
    bit  hold_request;
    int  used_n;

    dfa_minimizer_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Timeout guard
    initial
    begin
        #100ms;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [15:0] pack_item(dfam_pkg::op_t op, int si, int sym, int tgt,
                                              int acc);
        return {3'b000, acc[0], tgt[3:0], sym[1:0], si[3:0], op};
    endfunction

    // Offer one item and hold it until the transaction completes
    task automatic send_item(logic [15:0] d);
        int gap;
        gap = zero_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge clk); while (!s_tready);
        board.note_input(d);
    endtask

    task automatic write_reg(logic [1:0] idx, int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[4:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.set_reg(idx, val[4:0]);
    endtask

    // Drop valid and wait until every pending edge has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending_edges.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic send_random_item();
        int r;
        int si;
        r  = $urandom_range(0, 99);
        si = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, used_n - 1);
        if (r < 60)
            send_item(pack_item(dfam_pkg::OP_WRITE_TRANS, si, $urandom_range(0, 3),
                                $urandom_range(0, 15), $urandom_range(0, 1)));
        else if (r < 88)
            send_item(pack_item(dfam_pkg::OP_WRITE_ACCEPT, si, $urandom_range(0, 3),
                                $urandom_range(0, 15), $urandom_range(0, 1)));
        else if (r < 94)
            send_item(pack_item(dfam_pkg::OP_RUN, si, $urandom_range(0, 3),
                                $urandom_range(0, 15), 0));
        else
            send_item(pack_item(dfam_pkg::OP_NONE, si, $urandom_range(0, 3),
                                $urandom_range(0, 15), $urandom_range(0, 1)));
    endtask

    // Receiver: random stalls, one long hold-off on request once a result is waiting
    initial
    begin
        int stall_left;
        m_tready   = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                board.check_result(m_tdata, m_tlast);
                stall_left = zero_gaps ? 0 : $urandom_range(0, 19);
            end
            if (hold_request && m_tvalid)
            begin
                hold_request = 0;
                stall_left = 400;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Stimulus
    initial
    begin
        int cfg_n[8];
        int cfg_k[8];
        int cfg_st[8];
        cfg_n        = '{16, 1, 0, 31, 5, 16, 8, 16};
        cfg_k        = '{4, 1, 0, 7, 2, 4, 3, 1};
        cfg_st       = '{0, 0, 5, 15, 9, 15, 2, 7};
        board        = new();
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        zero_gaps    = 1;
        hold_request = 0;
        used_n       = 16;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole table so no run reads an unwritten entry
        for (int s = 0; s < 16; s++)
            for (int a = 0; a < 4; a++)
                send_item(pack_item(dfam_pkg::OP_WRITE_TRANS, s, a, (s + a + 1) % 16, 0));
        zero_gaps = 0;

        // Directed: accept extremes, unused opcode, run on defaults under a long stall
        send_item(pack_item(dfam_pkg::OP_WRITE_ACCEPT, 15, 3, 15, 1));
        send_item(pack_item(dfam_pkg::OP_WRITE_ACCEPT, 0, 0, 0, 1));
        send_item(pack_item(dfam_pkg::OP_WRITE_ACCEPT, 0, 0, 0, 0));
        send_item(pack_item(dfam_pkg::OP_NONE, 15, 3, 15, 1));
        send_item(pack_item(dfam_pkg::OP_WRITE_TRANS, 15, 3, 0, 1));
        send_item(pack_item(dfam_pkg::OP_WRITE_TRANS, 7, 1, 15, 0));
        hold_request = 1;
        send_item(pack_item(dfam_pkg::OP_RUN, 0, 0, 0, 0));
        send_item(pack_item(dfam_pkg::OP_WRITE_ACCEPT, 3, 0, 0, 1));
        send_item(pack_item(dfam_pkg::OP_RUN, 15, 3, 15, 1));
        drain();

        // Phases across register settings
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(dfam_pkg::CFG_NUM_STATES, cfg_n[ph]);
            write_reg(dfam_pkg::CFG_NUM_SYMBOLS, cfg_k[ph]);
            write_reg(dfam_pkg::CFG_START_STATE, cfg_st[ph]);
            used_n    = (cfg_n[ph] < 1) ? 1 : ((cfg_n[ph] > 16) ? 16 : cfg_n[ph]);
            zero_gaps = (ph == 3);
            repeat (3) send_random_item();
            send_item(pack_item(dfam_pkg::OP_RUN, 0, 0, 0, 0));
            drain();
        end

        if (board.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

>>> dfa_minimizer_core.f
hw/rtl/dfam_pkg.sv
hw/rtl/dfam_ram.sv
hw/rtl/dfa_minimizer_core.sv
hw/rtl/dfam_checker.sv
sim/dfa_minimizer_core_tb.sv
